// ===== hw/rtl/tsc_pkg.sv =====
// Shared widths and bit-level helpers for the token string checksum core.
// The hash step and the top level depend on this package.
`timescale 1ns / 1ps

package tsc_pkg;

	// Width of one token character.
	localparam int CharW = 8;
	// Width of the running sum as seen by software.
	localparam int SumW = 64;
	// Only the low 31 bits of each product survive the mask.
	localparam int MaskW = 31;
	// Width of the reported checksum.
	localparam int CheckW = 32;

	typedef logic [MaskW-1:0]  mask_t;
	typedef logic [SumW-1:0]   sum_t;
	typedef logic [CheckW-1:0] check_t;

	// Interleaving permutation applied to a masked product. Input bits above
	// the mask are zero, so masked bit k lands on sum bit (62 - 2k). Every
	// other sum bit is zero.
	function automatic sum_t interleave(input mask_t m);
		sum_t r;
		r = '0;
		for (int k = 0; k < MaskW; k++) begin
			r[SumW - 2 - 2 * k] = m[k];
		end
		return r;
	endfunction

	// Sign extension of one character to the masked width.
	function automatic mask_t sext_char(input logic signed [CharW-1:0] c);
		return {{(MaskW - CharW){c[CharW-1]}}, c};
	endfunction

	// Sum modulo 2^32 - 1 of a permuted value. Both halves hold ones only at
	// even positions, so adding them never ripples a carry past one bit,
	// the sum stays below 2^32 - 1 and no end-around carry is needed.
	function automatic check_t fold_mod(input sum_t s);
		check_t hi;
		check_t lo;
		hi = s[SumW-1:CheckW];
		lo = s[CheckW-1:0];
		return (hi ^ lo) | ((hi & lo) << 1);
	endfunction

endpackage

// ===== hw/rtl/tsc_step.sv =====
// One update of the token hash: add, invert, multiply and mask, plus the
// checksum of the updated sum. Depends on tsc_pkg.
`timescale 1ns / 1ps

module tsc_step (
	input  tsc_pkg::mask_t            masked_sum,
	input  logic signed [7:0]         char_byte,
	output tsc_pkg::mask_t            next_masked_sum,
	output tsc_pkg::check_t           checksum
);

	tsc_pkg::sum_t  sum_cur;
	tsc_pkg::mask_t char_ext;
	tsc_pkg::mask_t sum_added;
	tsc_pkg::mask_t sum_inv;

	// The running sum is kept as the masked product ahead of the permutation.
	// Only its low 31 bits take part in the next product.
	assign sum_cur   = tsc_pkg::interleave(masked_sum);
	assign char_ext  = tsc_pkg::sext_char(char_byte);
	assign sum_added = sum_cur[tsc_pkg::MaskW-1:0] + char_ext;
	assign sum_inv   = ~sum_added;

	// Truncated 31 by 31 product, which equals the masked 64-bit product.
	assign next_masked_sum = sum_inv * char_ext;

	// Checksum of the updated sum, used when this word ends the token.
	assign checksum = tsc_pkg::fold_mod(tsc_pkg::interleave(next_masked_sum));

endmodule

// ===== hw/rtl/token_string_checksum_core.sv =====
// Top level of the token string checksum core: input register, hash state
// and result register. Depends on tsc_pkg and tsc_step.
//
//   channel | handshake           | payload
//   --------+---------------------+--------------------
//   in      | in_valid, in_stall  | char_byte, is_last
//   out     | out_valid, out_stall| checksum
//
// One word is accepted per cycle unless in_stall is high; each passes an input register and then one
// add and one 31-bit multiply before the hash state and result register.
// A checksum is loaded into the result register when the last word of its
// token leaves the input register.
// Reset clears the hash state and both valid flags.
// A stalled result holds; words that do not end a token keep flowing past it,
// and a final word waits in the input register until the result is taken.
`timescale 1ns / 1ps

module token_string_checksum_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic signed [7:0]     char_byte,
	input  logic                  is_last,
	output logic                  out_valid,
	input  logic                  out_stall,
	output tsc_pkg::check_t       checksum
);

	logic                      valid_s1;
	logic signed [7:0]         char_s1;
	logic                      last_s1;
	tsc_pkg::mask_t            sum_q;
	tsc_pkg::mask_t            sum_next;
	tsc_pkg::check_t           check_next;
	logic                      out_valid_q;
	tsc_pkg::check_t           checksum_q;
	logic                      out_room;
	logic                      fire_s1;
	logic                      load_s1;

	// Handshake: a word leaves stage 1 unless it ends a token and the result
	// register is still full and stalled.
	assign out_room = !out_valid_q || !out_stall;
	assign fire_s1  = valid_s1 && (!last_s1 || out_room);
	assign in_stall = valid_s1 && !fire_s1;
	assign load_s1  = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || fire_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			char_s1 <= char_byte;
			last_s1 <= is_last;
		end
	end

	// Hash arithmetic for the word in stage 1.
	tsc_step u_step (
		.masked_sum      (sum_q),
		.char_byte       (char_s1),
		.next_masked_sum (sum_next),
		.checksum        (check_next)
	);

	// Hash state, cleared at the end of each token.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (fire_s1) begin
			sum_q <= last_s1 ? '0 : sum_next;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_room) begin
			out_valid_q <= fire_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			checksum_q <= check_next;
		end
	end

	assign out_valid = out_valid_q;
	assign checksum  = checksum_q;

endmodule
